// ===== rtl/core/lsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfb_pkg: shared types and constants of the LED strip frame buffer
// Field widths, opcodes, register indexes, the command record passed from the
// front end to the back end, and the pixel word layout.
// ----------------------------------------------------------------------------
package lsfb_pkg;

   // Store geometry.
   localparam int MAX_LEDS  = 32;
   localparam int LED_IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int LED_CNT_W = $clog2(MAX_LEDS + 1);

   // Transaction field widths.
   localparam int OPCODE_W      = 3;
   localparam int PIXEL_INDEX_W = 6;
   localparam int COLOR_W       = 8;
   localparam int PIX_BR_W      = 8;
   localparam int ROT_W         = 16;
   localparam int WORD_W        = 32;
   localparam int BR_W          = 5;
   localparam int LED_COUNT_W   = 6;
   localparam int CMP_W         = (PIXEL_INDEX_W > LED_CNT_W) ? PIXEL_INDEX_W : LED_CNT_W;
   localparam int ROT_STEP_W    = $clog2(ROT_W);

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_GLOBAL_BR = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_LED_COUNT = 1'd1;
   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET = 6'd32;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_SET_GLOBAL = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_SET_OWN    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FILL       = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SHOW       = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DIRECT     = 3'd5;

   // Word constants.
   localparam logic [BR_W-1:0]   BR_MAX       = 5'd31;
   localparam logic [2:0]        PIX_PREAMBLE = 3'b111;
   localparam logic [WORD_W-1:0] START_WORD   = 32'h0000_0000;
   localparam logic [WORD_W-1:0] END_WORD     = 32'hFFFF_FFFF;

   // Command queue.
   localparam int CMD_FIFO_DEPTH = 2;

   typedef struct packed {
      logic [BR_W-1:0]    br;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } pixel_type;

   typedef enum logic [2:0] {
      CMD_WRITE,
      CMD_FILL,
      CMD_CLEAR,
      CMD_SHOW,
      CMD_DIRECT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [LED_IDX_W-1:0] index;
      pixel_type            pixel;
      logic [LED_IDX_W-1:0] start;
      logic [LED_CNT_W-1:0] count;
   } cmd_type;

endpackage

// ===== rtl/core/lsfb_req_if.sv =====
// ----------------------------------------------------------------------------
// lsfb_req_if: request channel
// Valid/ready channel that carries one frame buffer operation per transaction.
// ----------------------------------------------------------------------------
interface lsfb_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lsfb_pkg::OPCODE_W-1:0]        opcode;
   logic [lsfb_pkg::PIXEL_INDEX_W-1:0]   pixel_index;
   logic [lsfb_pkg::COLOR_W-1:0]         red;
   logic [lsfb_pkg::COLOR_W-1:0]         green;
   logic [lsfb_pkg::COLOR_W-1:0]         blue;
   logic [lsfb_pkg::PIX_BR_W-1:0]        pixel_brightness;
   logic signed [lsfb_pkg::ROT_W-1:0]    rotation;

   modport source (
      output valid, opcode, pixel_index, red, green, blue, pixel_brightness, rotation,
      input  ready
   );
   modport sink (
      input  valid, opcode, pixel_index, red, green, blue, pixel_brightness, rotation,
      output ready
   );
endinterface

// ===== rtl/core/lsfb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lsfb_rsp_if: response channel
// Valid/ready channel that carries one 32-bit strip word per transaction.
// ----------------------------------------------------------------------------
interface lsfb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsfb_pkg::WORD_W-1:0]   frame_word;
   logic                          last_word;

   modport source (
      output valid, frame_word, last_word,
      input  ready
   );
   modport sink (
      input  valid, frame_word, last_word,
      output ready
   );
endinterface

// ===== rtl/core/led_strip_frame_buffer_top.sv =====
// ----------------------------------------------------------------------------
// led_strip_frame_buffer_top: LED strip frame buffer
// Pixel store with set, fill, clear, show and direct write operations that
// produces strip words, plus brightness and LED count registers.
// ----------------------------------------------------------------------------
// Set and clear take effect after the front end register and the command queue;
// fill walks all 32 entries. Show: a serial remainder of the rotation, then count
// plus two words at one per cycle while the output is not stalled. Direct write:
// its word passes the front end register, the queue and the output register. A
// new request is taken once the previous command has been handed to the queue.
// Reset clears all control state and marks every pixel entry as zero at once.
module led_strip_frame_buffer_top (
   input  logic                            clock,
   input  logic                            reset,
   lsfb_req_if.sink                        req_bus,
   lsfb_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lsfb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lsfb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lsfb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lsfb_pkg::*;

   logic [BR_W-1:0]        gbr_ff;
   logic [LED_COUNT_W-1:0] led_count_ff;
   logic [LED_CNT_W-1:0]   eff_count;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   csr_write;
   logic                   push_valid;
   logic                   push_ready;
   cmd_type                push_data;
   logic                   pop_valid;
   logic                   pop_ready;
   cmd_type                pop_data;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gbr_ff       <= '0;
         led_count_ff <= LED_COUNT_RESET;
      end else if (csr_write) begin
         case (reg_idx)
            REG_GLOBAL_BR: gbr_ff <= csr_pwdata[BR_W-1:0];
            REG_LED_COUNT: led_count_ff <= csr_pwdata[LED_COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GLOBAL_BR: csr_prdata = CSR_DATA_W'(gbr_ff);
         REG_LED_COUNT: csr_prdata = CSR_DATA_W'(led_count_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign eff_count = (led_count_ff > LED_COUNT_W'(MAX_LEDS)) ?
                      LED_CNT_W'(MAX_LEDS) : LED_CNT_W'(led_count_ff);

   lsfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .global_br (gbr_ff),
      .led_count (eff_count),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd       (push_data)
   );

   lsfb_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lsfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_pop   (pop_ready),
      .cmd       (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/core/lsfb_rem_unit.sv =====
// ----------------------------------------------------------------------------
// lsfb_rem_unit: serial remainder unit
// Restoring division of the rotation magnitude by the LED count, one dividend
// bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module lsfb_rem_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lsfb_pkg::ROT_W-1:0]     dividend,
   input  logic [lsfb_pkg::LED_CNT_W-1:0] divisor,
   output logic                           done,
   output logic [lsfb_pkg::LED_CNT_W-1:0] remainder
);
   import lsfb_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROT_STEP_W-1:0] step_ff, step_in;
   logic [LED_CNT_W-1:0]  rem_ff, rem_in;
   logic [ROT_W-1:0]      dvd_ff, dvd_in;
   logic [LED_CNT_W-1:0]  div_ff, div_in;
   logic [LED_CNT_W:0]    trial;
   logic [LED_CNT_W:0]    diff;
   logic                  fits;

   // The partial remainder stays below the divisor, so one extra bit holds the trial.
   assign trial = {rem_ff, dvd_ff[ROT_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[LED_CNT_W-1:0] : trial[LED_CNT_W-1:0];
         dvd_in  = {dvd_ff[ROT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == ROT_STEP_W'(ROT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/lsfb_front.sv =====
// ----------------------------------------------------------------------------
// lsfb_front: request decoder
// Accepts request transactions, drops those that do nothing, resolves
// brightness and the show start entry, and hands commands to the queue.
// ----------------------------------------------------------------------------
module lsfb_front (
   input  logic                           clock,
   input  logic                           reset,
   lsfb_req_if.sink                       req_bus,
   input  logic [lsfb_pkg::BR_W-1:0]      global_br,
   input  logic [lsfb_pkg::LED_CNT_W-1:0] led_count,
   output logic                           cmd_valid,
   input  logic                           cmd_ready,
   output lsfb_pkg::cmd_type              cmd
);
   import lsfb_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_HOLD = 2'd2;

   logic [1:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 neg_ff, neg_in;
   logic                 accept;
   logic [BR_W-1:0]      own_br;
   logic [ROT_W-1:0]     rot_u;
   logic [ROT_W-1:0]     rot_mag;
   logic                 idx_ok;
   logic                 div_start;
   logic                 div_done;
   logic [LED_CNT_W-1:0] div_rem;
   logic [LED_IDX_W-1:0] start_idx;

   assign req_bus.ready = (state_ff == F_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign own_br = (req_bus.pixel_brightness > PIX_BR_W'(BR_MAX)) ?
                   BR_MAX : req_bus.pixel_brightness[BR_W-1:0];
   assign idx_ok = CMP_W'(req_bus.pixel_index) < CMP_W'(led_count);

   assign rot_u   = $unsigned(req_bus.rotation);
   assign rot_mag = rot_u[ROT_W-1] ? ROT_W'(~rot_u + 1'b1) : rot_u;

   // Output pixel 0 shows entry (-rotation) mod count; for a negative rotation
   // that is the remainder of the magnitude, otherwise count minus it.
   assign start_idx = neg_ff ? LED_IDX_W'(div_rem) :
                      ((div_rem == '0) ? '0 : LED_IDX_W'(cmd_ff.count - div_rem));

   lsfb_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rot_mag),
      .divisor   (led_count),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      neg_in    = neg_ff;
      div_start = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               cmd_in.index       = req_bus.pixel_index[LED_IDX_W-1:0];
               cmd_in.pixel.br    = global_br;
               cmd_in.pixel.blue  = req_bus.blue;
               cmd_in.pixel.green = req_bus.green;
               cmd_in.pixel.red   = req_bus.red;
               cmd_in.start       = '0;
               cmd_in.count       = led_count;
               cmd_in.kind        = CMD_WRITE;
               neg_in             = rot_u[ROT_W-1];
               case (req_bus.opcode)
                  OP_SET_GLOBAL: begin
                     if (idx_ok) begin
                        state_in = F_HOLD;
                     end
                  end
                  OP_SET_OWN: begin
                     cmd_in.pixel.br = own_br;
                     if (idx_ok) begin
                        state_in = F_HOLD;
                     end
                  end
                  OP_FILL: begin
                     cmd_in.kind = CMD_FILL;
                     state_in    = F_HOLD;
                  end
                  OP_CLEAR: begin
                     cmd_in.kind = CMD_CLEAR;
                     state_in    = F_HOLD;
                  end
                  OP_SHOW: begin
                     cmd_in.kind = CMD_SHOW;
                     if (led_count == '0) begin
                        state_in = F_HOLD;
                     end else begin
                        div_start = 1'b1;
                        state_in  = F_DIV;
                     end
                  end
                  OP_DIRECT: begin
                     cmd_in.kind     = CMD_DIRECT;
                     cmd_in.pixel.br = own_br;
                     state_in        = F_HOLD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         F_DIV: begin
            if (div_done) begin
               cmd_in.start = start_idx;
               state_in     = F_HOLD;
            end
         end
         F_HOLD: begin
            if (cmd_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      neg_ff <= neg_in;
   end

   assign cmd_valid = (state_ff == F_HOLD);
   assign cmd       = cmd_ff;

endmodule

// ===== rtl/core/lsfb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lsfb_cmd_fifo: command queue
// Short first-in first-out queue of decoded commands between the front end and
// the back end.
// ----------------------------------------------------------------------------
module lsfb_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lsfb_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lsfb_pkg::cmd_type pop_data
);
   import lsfb_pkg::*;

   localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type            entries_ff [CMD_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(CMD_FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/lsfb_back.sv =====
// ----------------------------------------------------------------------------
// lsfb_back: pixel store and word sequencer
// Carries out queued commands against the pixel store and streams the strip
// words of a show or direct write through the output register.
// ----------------------------------------------------------------------------
module lsfb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  lsfb_pkg::cmd_type cmd,
   lsfb_rsp_if.source        rsp_bus
);
   import lsfb_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_BODY = 3'd2;
   localparam logic [2:0] ST_TAIL = 3'd3;

   localparam logic [1:0] SEL_START  = 2'd0;
   localparam logic [1:0] SEL_PIXEL  = 2'd1;
   localparam logic [1:0] SEL_DIRECT = 2'd2;
   localparam logic [1:0] SEL_END    = 2'd3;

   pixel_type             store_mem [MAX_LEDS];
   logic [MAX_LEDS-1:0]   valid_ff;
   logic [2:0]            state_ff, state_in;
   logic [LED_IDX_W-1:0]  ptr_ff, ptr_in;
   logic [LED_CNT_W-1:0]  remain_ff, remain_in;
   logic [LED_CNT_W-1:0]  count_ff, count_in;
   pixel_type             pix_ff, pix_in;
   logic                  rsp_valid_ff;
   logic [WORD_W-1:0]     word_ff;
   logic                  last_ff;
   logic                  out_free;
   logic                  out_load;
   logic [1:0]            out_sel;
   logic                  out_last;
   logic                  mem_we;
   logic [LED_IDX_W-1:0]  mem_addr;
   pixel_type             mem_wdata;
   logic                  clear_all;
   logic                  ptr_wrap;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign ptr_wrap = (LED_CNT_W'(ptr_ff) + LED_CNT_W'(1)) == count_ff;

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      pix_in    = pix_ff;
      cmd_pop   = 1'b0;
      mem_we    = 1'b0;
      mem_addr  = ptr_ff;
      mem_wdata = pix_ff;
      clear_all = 1'b0;
      out_load  = 1'b0;
      out_sel   = SEL_START;
      out_last  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_WRITE: begin
                     cmd_pop   = 1'b1;
                     mem_we    = 1'b1;
                     mem_addr  = cmd.index;
                     mem_wdata = cmd.pixel;
                  end
                  CMD_CLEAR: begin
                     cmd_pop   = 1'b1;
                     clear_all = 1'b1;
                  end
                  CMD_FILL: begin
                     cmd_pop  = 1'b1;
                     pix_in   = cmd.pixel;
                     ptr_in   = '0;
                     state_in = ST_FILL;
                  end
                  CMD_SHOW: begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        out_load  = 1'b1;
                        out_sel   = SEL_START;
                        ptr_in    = cmd.start;
                        count_in  = cmd.count;
                        remain_in = cmd.count;
                        state_in  = (cmd.count == '0) ? ST_TAIL : ST_BODY;
                     end
                  end
                  CMD_DIRECT: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        out_load = 1'b1;
                        out_sel  = SEL_DIRECT;
                        out_last = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            ptr_in = LED_IDX_W'(ptr_ff + 1'b1);
            if (ptr_ff == LED_IDX_W'(MAX_LEDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_BODY: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_sel   = SEL_PIXEL;
               ptr_in    = ptr_wrap ? '0 : LED_IDX_W'(ptr_ff + 1'b1);
               remain_in = remain_ff - 1'b1;
               if (remain_ff == LED_CNT_W'(1)) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               out_load = 1'b1;
               out_sel  = SEL_END;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Entries never written since reset or the last clear read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (clear_all) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_addr] <= 1'b1;
      end
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         case (out_sel)
            SEL_START: word_ff <= START_WORD;
            SEL_PIXEL: word_ff <= {PIX_PREAMBLE, valid_ff[ptr_ff] ? store_mem[ptr_ff] : '0};
            SEL_DIRECT: word_ff <= {PIX_PREAMBLE, cmd.pixel};
            SEL_END: word_ff <= END_WORD;
            default: word_ff <= START_WORD;
         endcase
         last_ff <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      ptr_ff    <= ptr_in;
      remain_ff <= remain_in;
      count_ff  <= count_in;
      pix_ff    <= pix_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.frame_word = word_ff;
   assign rsp_bus.last_word  = last_ff;

   a_pop_only_idle : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE))
      else $error("command taken while a previous command is in progress");

   a_body_has_words : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY) |-> (remain_ff != '0))
      else $error("show body entered with no pixel words left");

   a_body_ptr_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BODY) |-> (LED_CNT_W'(ptr_ff) < count_ff))
      else $error("show read pointer beyond the LED count");

   a_tail_marks_last : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TAIL) && out_free) |=> (rsp_valid_ff && last_ff && (state_ff == ST_IDLE)))
      else $error("end word of a show not flagged as last");

endmodule
